/* rtl/core/nnd_pkg.sv */
// ----------------------------------------------------------------------------
// Nearest-neighbour downscaler package
// Shared widths, register indices, bus structs and the target-size function.
// ----------------------------------------------------------------------------
package nnd_pkg;

  localparam int unsigned PIX_W   = 8;   // palette index
  localparam int unsigned REG_W   = 12;  // configuration register width
  localparam int unsigned IDX_W   = 4;   // configuration register index width
  localparam int unsigned LOG_W   = 4;   // log2 of the target size, at most 11
  localparam int unsigned TGT_W   = 12;  // target size and output counters, up to 2048

  // Largest power of two that is kept as the target size.
  localparam int unsigned SMALL_POW_MAX = 256;

  // Register reset value.
  localparam logic [REG_W-1:0] REG_RESET = 12'd256;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_DIMENSION_DEF = 2048;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Register indices.
  localparam logic [IDX_W-1:0] REG_HEADER_WIDTH  = 4'd0;
  localparam logic [IDX_W-1:0] REG_HEADER_HEIGHT = 4'd1;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 4'd2;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 4'd3;

  // Target geometry handed from the configuration block to the scan logic.
  typedef struct packed {
    logic [TGT_W-1:0] tw;
    logic [TGT_W-1:0] th;
    logic             upscale;
  } nnd_tgt_t;

  // Decision for the transaction being accepted.
  typedef struct packed {
    logic emit;
    logic last;
    logic upscale;
  } nnd_res_t;

  // log2 of the power-of-two target for a header size. Powers of two up to
  // the limit are kept, larger powers of two are halved and anything else
  // rounds down to the power of two below it.
  function automatic logic [LOG_W-1:0] target_log(input logic [REG_W-1:0] h);
    logic [REG_W-1:0] hv;
    logic [LOG_W-1:0] p;
    hv = (h == '0) ? REG_W'(1) : h;
    p  = '0;
    for (int i = 1; i < REG_W; i++) begin
      if (hv[i]) begin
        p = LOG_W'(i);
      end
    end
    if (((hv & (hv - REG_W'(1))) == '0) && (hv > REG_W'(SMALL_POW_MAX))) begin
      p = p - LOG_W'(1);
    end
    return p;
  endfunction

endpackage

/* rtl/core/nnd_cfg.sv */
// ----------------------------------------------------------------------------
// Downscaler configuration
// Holds the size registers and registers the clamped sizes, target sizes and
// accumulator steps derived from them.
// ----------------------------------------------------------------------------
module nnd_cfg #(
  parameter int unsigned MAX_DIMENSION = nnd_pkg::MAX_DIMENSION_DEF,
  parameter int unsigned FRACTION_BITS = nnd_pkg::FRACTION_BITS_DEF,
  localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1),
  localparam int unsigned ACC_W = DIM_W + FRACTION_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [nnd_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [nnd_pkg::REG_W-1:0]   cfg_data_i,
  output logic                        clear_o,
  output logic                        busy_o,
  output logic [DIM_W-1:0]            iw_o,
  output logic [DIM_W-1:0]            ih_o,
  output logic [ACC_W-1:0]            col_step_o,
  output logic [ACC_W-1:0]            row_step_o,
  output nnd_pkg::nnd_tgt_t           tgt_o
);

  localparam int unsigned CMP_W = (DIM_W > nnd_pkg::TGT_W) ? DIM_W : nnd_pkg::TGT_W;

  logic [nnd_pkg::REG_W-1:0] hdr_w_q, hdr_h_q, img_w_q, img_h_q;
  logic                      pend_q;
  logic                      wr;
  logic [DIM_W-1:0]          iw_d, ih_d, iw_q, ih_q;
  logic [nnd_pkg::LOG_W-1:0] lw, lh;
  logic [ACC_W-1:0]          col_step_d, row_step_d, col_step_q, row_step_q;
  nnd_pkg::nnd_tgt_t         tgt_d, tgt_q;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [nnd_pkg::REG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > int'(MAX_DIMENSION)) begin
      r = DIM_W'(MAX_DIMENSION);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_w_q <= nnd_pkg::REG_RESET;
      hdr_h_q <= nnd_pkg::REG_RESET;
      img_w_q <= nnd_pkg::REG_RESET;
      img_h_q <= nnd_pkg::REG_RESET;
    end else if (wr) begin
      case (cfg_index_i)
        nnd_pkg::REG_HEADER_WIDTH:  hdr_w_q <= cfg_data_i;
        nnd_pkg::REG_HEADER_HEIGHT: hdr_h_q <= cfg_data_i;
        nnd_pkg::REG_IMAGE_WIDTH:   img_w_q <= cfg_data_i;
        nnd_pkg::REG_IMAGE_HEIGHT:  img_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Only a write to a known register restarts the frame.
  always_comb begin
    case (cfg_index_i)
      nnd_pkg::REG_HEADER_WIDTH,
      nnd_pkg::REG_HEADER_HEIGHT,
      nnd_pkg::REG_IMAGE_WIDTH,
      nnd_pkg::REG_IMAGE_HEIGHT: clear_o = wr;
      default:                   clear_o = 1'b0;
    endcase
  end

  // The derived values are registered from the size registers, so the stream
  // input is held off in the cycle after any write and straight after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b1;
    end else begin
      pend_q <= wr;
    end
  end

  always_comb begin
    iw_d       = clamp_dim(img_w_q);
    ih_d       = clamp_dim(img_h_q);
    lw         = nnd_pkg::target_log(hdr_w_q);
    lh         = nnd_pkg::target_log(hdr_h_q);
    tgt_d.tw   = nnd_pkg::TGT_W'(1) << lw;
    tgt_d.th   = nnd_pkg::TGT_W'(1) << lh;
    col_step_d = ACC_W'({iw_d, {FRACTION_BITS{1'b0}}}) >> lw;
    row_step_d = ACC_W'({ih_d, {FRACTION_BITS{1'b0}}}) >> lh;
    tgt_d.upscale = (CMP_W'(iw_d) < CMP_W'(tgt_d.tw)) ||
                    (CMP_W'(ih_d) < CMP_W'(tgt_d.th));
  end

  always_ff @(posedge clk_i) begin
    iw_q       <= iw_d;
    ih_q       <= ih_d;
    col_step_q <= col_step_d;
    row_step_q <= row_step_d;
    tgt_q      <= tgt_d;
  end

  assign busy_o     = pend_q;
  assign iw_o       = iw_q;
  assign ih_o       = ih_q;
  assign col_step_o = col_step_q;
  assign row_step_o = row_step_q;
  assign tgt_o      = tgt_q;

endmodule

/* rtl/core/nnd_scan.sv */
// ----------------------------------------------------------------------------
// Downscaler scan position
// Tracks source and output positions and the default 12.16 accumulators and
// decides whether the accepted pixel is kept.
// ----------------------------------------------------------------------------
module nnd_scan #(
  parameter int unsigned MAX_DIMENSION = nnd_pkg::MAX_DIMENSION_DEF,
  parameter int unsigned FRACTION_BITS = nnd_pkg::FRACTION_BITS_DEF,
  localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1),
  localparam int unsigned ACC_W = DIM_W + FRACTION_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              clear_i,
  input  logic [DIM_W-1:0]  iw_i,
  input  logic [DIM_W-1:0]  ih_i,
  input  logic [ACC_W-1:0]  col_step_i,
  input  logic [ACC_W-1:0]  row_step_i,
  input  nnd_pkg::nnd_tgt_t tgt_i,
  output nnd_pkg::nnd_res_t res_o
);

  localparam int unsigned TGT_W = nnd_pkg::TGT_W;

  logic [DIM_W-1:0] src_col_q, src_col_d, src_row_q, src_row_d;
  logic [TGT_W-1:0] out_col_q, out_col_d, out_row_q, out_row_d;
  logic [ACC_W-1:0] col_acc_q, col_acc_d, row_acc_q, row_acc_d;
  logic             col_end, row_end, row_hit, col_hit;

  always_comb begin
    col_end = ({1'b0, src_col_q} + (DIM_W + 1)'(1)) >= {1'b0, iw_i};
    row_end = ({1'b0, src_row_q} + (DIM_W + 1)'(1)) >= {1'b0, ih_i};
    row_hit = !tgt_i.upscale && (out_row_q < tgt_i.th) &&
              (src_row_q == row_acc_q[ACC_W-1:FRACTION_BITS]);
    col_hit = !tgt_i.upscale && (out_col_q < tgt_i.tw) &&
              (src_col_q == col_acc_q[ACC_W-1:FRACTION_BITS]);

    res_o.upscale = tgt_i.upscale;
    if (tgt_i.upscale) begin
      res_o.emit = 1'b1;
      res_o.last = row_end && col_end;
    end else begin
      res_o.emit = row_hit && col_hit;
      res_o.last = ((out_row_q + TGT_W'(1)) == tgt_i.th) &&
                   ((out_col_q + TGT_W'(1)) == tgt_i.tw);
    end
  end

  always_comb begin
    src_col_d = src_col_q;
    src_row_d = src_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    col_acc_d = col_acc_q;
    row_acc_d = row_acc_q;
    if (clear_i) begin
      src_col_d = '0;
      src_row_d = '0;
      out_col_d = '0;
      out_row_d = '0;
      col_acc_d = '0;
      row_acc_d = '0;
    end else if (accept_i) begin
      // Passthrough keeps the output counters parked at zero.
      if (tgt_i.upscale) begin
        out_col_d = '0;
        out_row_d = '0;
      end else if (col_hit) begin
        out_col_d = out_col_q + TGT_W'(1);
        col_acc_d = col_acc_q + col_step_i;
      end
      if (col_end) begin
        src_col_d = '0;
        out_col_d = '0;
        col_acc_d = '0;
        if (row_hit) begin
          out_row_d = out_row_q + TGT_W'(1);
          row_acc_d = row_acc_q + row_step_i;
        end
        if (row_end) begin
          src_row_d = '0;
          out_row_d = '0;
          row_acc_d = '0;
        end else begin
          src_row_d = src_row_q + DIM_W'(1);
        end
      end else begin
        src_col_d = src_col_q + DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      col_acc_q <= '0;
      row_acc_q <= '0;
    end else begin
      src_col_q <= src_col_d;
      src_row_q <= src_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      col_acc_q <= col_acc_d;
      row_acc_q <= row_acc_d;
    end
  end

`ifndef SYNTHESIS
  a_clear_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_i |=> (src_col_q == '0) && (src_row_q == '0) && (out_col_q == '0) &&
                (out_row_q == '0) && (col_acc_q == '0) && (row_acc_q == '0))
    else $error("frame position not cleared after a register write");

  a_pass_parks_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && tgt_i.upscale) |=> (out_col_q == '0) && (out_row_q == '0))
    else $error("output counters moved during passthrough");

  a_row_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !clear_i && col_end) |=> (src_col_q == '0) && (col_acc_q == '0))
    else $error("column state not reset at end of a source row");
`endif

endmodule

/* rtl/core/nearest_neighbor_pow2_downscaler.sv */
// ----------------------------------------------------------------------------
// Nearest-neighbour power-of-two downscaler
// Resamples a raster stream of palette-index pixels to a power-of-two size.
// ----------------------------------------------------------------------------
// One pixel transaction is accepted per clock cycle unless the input is held
// off or a waiting result is not taken, and at most one result appears in
// the next cycle through a registered output stage, which keeps taking
// pixels while a result waits as long as the result is taken in the same
// cycle. The keep-or-drop decision is a compare of the source position
// against the integer part of the row and column accumulators. After reset
// and after every configuration write the stream input is held off while
// the clamped sizes and accumulator steps are registered. A write to a known
// register restarts the frame. Dropped pixels produce no output; tlast marks
// the final pixel of the resampled frame and tuser marks pixels passed
// unscaled because the image is smaller than the target in either dimension.
module nearest_neighbor_pow2_downscaler #(
  parameter int unsigned MAX_DIMENSION = nnd_pkg::MAX_DIMENSION_DEF,
  parameter int unsigned FRACTION_BITS = nnd_pkg::FRACTION_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Configuration write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [nnd_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [nnd_pkg::REG_W-1:0] cfg_data_i,
  // Pixel input
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] pixel_in
  // Pixel output
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,   // [7:0] pixel_out
  output logic                      m_axis_tlast,   // frame_last
  output logic                      m_axis_tuser    // [0] upscale_flag
);

  localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned ACC_W = DIM_W + FRACTION_BITS;

  logic                      clear, busy, accept;
  logic [DIM_W-1:0]          iw, ih;
  logic [ACC_W-1:0]          col_step, row_step;
  nnd_pkg::nnd_tgt_t         tgt;
  nnd_pkg::nnd_res_t         res;

  logic                      out_valid_q, out_valid_d;
  logic [nnd_pkg::PIX_W-1:0] out_pix_q;
  logic                      out_last_q, out_user_q;

  nnd_cfg #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .clear_o     (clear),
    .busy_o      (busy),
    .iw_o        (iw),
    .ih_o        (ih),
    .col_step_o  (col_step),
    .row_step_o  (row_step),
    .tgt_o       (tgt)
  );

  nnd_scan #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .clear_i    (clear),
    .iw_i       (iw),
    .ih_i       (ih),
    .col_step_i (col_step),
    .row_step_i (row_step),
    .tgt_i      (tgt),
    .res_o      (res)
  );

  assign s_axis_tready = !busy && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = res.emit;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res.emit) begin
      out_pix_q  <= s_axis_tdata;
      out_last_q <= res.last;
      out_user_q <= res.upscale;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
  a_kept_pixel_shown : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res.emit) |=> m_axis_tvalid)
    else $error("kept pixel did not reach the output register");

  a_hold_after_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> !s_axis_tready)
    else $error("pixel input open while derived sizes settle");

  a_out_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata) &&
                                          $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("waiting output transaction changed before it was taken");
`endif

endmodule
